/* design/iocr_pkg.sv */
package iocr_pkg;

   localparam int CAPACITY_DEFAULT   = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int REQ_TYPE_W = 3;
   localparam int PAYLOAD_W  = 32;
   localparam int SLOT_W     = 4;
   localparam int STATUS_W   = 2;
   localparam int CORDON_W   = 5;
   localparam int STATE_W    = 2;

   localparam int CORDON_RESET = 5;

   localparam logic [REQ_TYPE_W-1:0] REQ_PUSH     = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_DISPATCH = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_COMPLETE = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_RETIRE   = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] REQ_TRUNCATE = 3'd4;
   localparam logic [REQ_TYPE_W-1:0] REQ_FINISH   = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_READY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_END       = 2'd2;

   localparam logic [STATE_W-1:0] SLOT_FREE       = 2'd0;
   localparam logic [STATE_W-1:0] SLOT_FILLED     = 2'd1;
   localparam logic [STATE_W-1:0] SLOT_DISPATCHED = 2'd2;
   localparam logic [STATE_W-1:0] SLOT_DONE       = 2'd3;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic [PAYLOAD_W-1:0]  payload;
      logic                  is_end;
      logic [SLOT_W-1:0]     slot_in;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [SLOT_W-1:0]    slot_out;
      logic [PAYLOAD_W-1:0] payload_out;
      logic [SLOT_W-1:0]    occupancy;
      logic                 below_cordon;
   } rsp_item_type;

   typedef struct packed {
      logic               end_mark;
      logic [STATE_W-1:0] state;
   } slot_meta_type;

endpackage

/* design/iocr_slot_store.sv */
module iocr_slot_store #(
   parameter int CAPACITY   = iocr_pkg::CAPACITY_DEFAULT,
   parameter int DATA_WIDTH = iocr_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        rd_en,
   input  logic [$clog2(CAPACITY)-1:0] rd_addr,
   output iocr_pkg::slot_meta_type     rd_meta,
   output logic [DATA_WIDTH-1:0]       rd_data,
   input  logic [$clog2(CAPACITY)-1:0] wr_addr,
   input  logic                        meta_wr_en,
   input  iocr_pkg::slot_meta_type     wr_meta,
   input  logic                        data_wr_en,
   input  logic [DATA_WIDTH-1:0]       wr_data
);

   iocr_pkg::slot_meta_type meta_mem [CAPACITY];
   logic [DATA_WIDTH-1:0]   data_mem [CAPACITY];

   always_ff @(posedge clock) begin
      if (meta_wr_en) begin
         meta_mem[wr_addr] <= wr_meta;
      end
      if (rd_en) begin
         rd_meta <= meta_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (data_wr_en) begin
         data_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= data_mem[rd_addr];
      end
   end

endmodule

/* design/iocr_ctrl.sv */
module iocr_ctrl #(
   parameter int CAPACITY   = iocr_pkg::CAPACITY_DEFAULT,
   parameter int DATA_WIDTH = iocr_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  iocr_pkg::req_item_type               req_item,
   output logic                                 busy,
   input  logic                                 csr_wr_en,
   input  logic [iocr_pkg::CORDON_W-1:0]        csr_wr_data,
   output logic                                 mem_rd_en,
   output logic [$clog2(CAPACITY)-1:0]          mem_rd_addr,
   input  iocr_pkg::slot_meta_type              mem_rd_meta,
   input  logic [DATA_WIDTH-1:0]                mem_rd_data,
   output logic [$clog2(CAPACITY)-1:0]          mem_wr_addr,
   output logic                                 mem_meta_wr_en,
   output iocr_pkg::slot_meta_type              mem_wr_meta,
   output logic                                 mem_data_wr_en,
   output logic [DATA_WIDTH-1:0]                mem_wr_data,
   output logic                                 rsp_strobe,
   output iocr_pkg::rsp_item_type               rsp_item
);

   localparam int PW       = $clog2(CAPACITY);
   localparam int CMP_W    = (PW > iocr_pkg::CORDON_W) ? PW : iocr_pkg::CORDON_W;
   localparam int PAY_W    = iocr_pkg::PAYLOAD_W;
   localparam int SLOT_W   = iocr_pkg::SLOT_W;
   localparam int CORDON_FLOOR = (3 * CAPACITY) / 10;
   localparam int CORDON_MIN   = (3 * CAPACITY + 9) / 10;
   localparam int CORDON_RESET_EFF =
      (iocr_pkg::CORDON_RESET < CORDON_MIN) ? CORDON_FLOOR : iocr_pkg::CORDON_RESET;

   localparam logic [1:0] CTRL_CLEAR = 2'd0;
   localparam logic [1:0] CTRL_IDLE  = 2'd1;
   localparam logic [1:0] CTRL_EXEC  = 2'd2;

   function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
      ring_next = (p == PW'(CAPACITY - 1)) ? '0 : p + 1'b1;
   endfunction

   logic [1:0]              state_ff, state_in;
   logic [PW-1:0]           clear_ptr_ff, clear_ptr_in;
   logic [PW-1:0]           fill_ff, fill_in;
   logic [PW-1:0]           dispatch_ff, dispatch_in;
   logic [PW-1:0]           retire_ff, retire_in;
   logic [CMP_W-1:0]        cordon_ff, cordon_in;
   iocr_pkg::req_item_type  req_ff;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   iocr_pkg::rsp_item_type  rsp_item_ff, rsp_item_in;

   logic                    accept;
   logic                    slot_ok;
   logic [PW:0]             occ_wide;
   logic [PW-1:0]           occ;
   logic                    retired;

   assign busy   = reset | (state_ff != CTRL_IDLE);
   assign accept = start & ~busy;

   // read issue at accept
   always_comb begin
      mem_rd_en   = accept;
      mem_rd_addr = '0;
      case (req_item.req_type)
         iocr_pkg::REQ_PUSH:     mem_rd_addr = ring_next(fill_ff);
         iocr_pkg::REQ_DISPATCH: mem_rd_addr = dispatch_ff;
         iocr_pkg::REQ_COMPLETE: mem_rd_addr = PW'(req_item.slot_in);
         iocr_pkg::REQ_RETIRE:   mem_rd_addr = retire_ff;
         default:                mem_rd_addr = '0;
      endcase
   end

   assign cordon_in = csr_wr_en
      ? ((CMP_W'(csr_wr_data) < CMP_W'(CORDON_MIN)) ? CMP_W'(CORDON_FLOOR)
                                                     : CMP_W'(csr_wr_data))
      : cordon_ff;

   assign slot_ok = (PW + 1)'(req_ff.slot_in) < (PW + 1)'(CAPACITY);

   // clearing pass and execute: modify and write back
   always_comb begin
      state_in       = state_ff;
      clear_ptr_in   = clear_ptr_ff;
      fill_in        = fill_ff;
      dispatch_in    = dispatch_ff;
      retire_in      = retire_ff;
      mem_wr_addr    = '0;
      mem_meta_wr_en = 1'b0;
      mem_wr_meta    = '0;
      mem_data_wr_en = 1'b0;
      mem_wr_data    = DATA_WIDTH'(req_ff.payload);
      rsp_strobe_in  = 1'b0;
      rsp_item_in    = '0;
      retired        = 1'b0;
      rsp_item_in.status = iocr_pkg::STATUS_NOT_READY;
      case (state_ff)
         CTRL_CLEAR: begin
            mem_meta_wr_en = 1'b1;
            mem_wr_addr    = clear_ptr_ff;
            clear_ptr_in   = ring_next(clear_ptr_ff);
            if (clear_ptr_ff == PW'(CAPACITY - 1)) begin
               state_in = CTRL_IDLE;
            end
         end
         CTRL_IDLE: begin
            if (start) begin
               state_in = CTRL_EXEC;
            end
         end
         CTRL_EXEC: begin
            state_in      = CTRL_IDLE;
            rsp_strobe_in = 1'b1;
            case (req_ff.req_type)
               iocr_pkg::REQ_PUSH: begin
                  if (mem_rd_meta.state == iocr_pkg::SLOT_FREE) begin
                     mem_wr_addr          = fill_ff;
                     mem_meta_wr_en       = 1'b1;
                     mem_data_wr_en       = 1'b1;
                     mem_wr_meta.end_mark = req_ff.is_end;
                     mem_wr_meta.state    = iocr_pkg::SLOT_FILLED;
                     if (!req_ff.is_end) begin
                        fill_in = ring_next(fill_ff);
                     end
                     rsp_item_in.status = iocr_pkg::STATUS_OK;
                  end
               end
               iocr_pkg::REQ_DISPATCH: begin
                  if (mem_rd_meta.state == iocr_pkg::SLOT_FILLED) begin
                     if (mem_rd_meta.end_mark) begin
                        rsp_item_in.status = iocr_pkg::STATUS_END;
                     end else begin
                        mem_wr_addr             = dispatch_ff;
                        mem_meta_wr_en          = 1'b1;
                        mem_wr_meta.state       = iocr_pkg::SLOT_DISPATCHED;
                        rsp_item_in.slot_out    = SLOT_W'(dispatch_ff);
                        rsp_item_in.payload_out = PAY_W'(mem_rd_data);
                        dispatch_in             = ring_next(dispatch_ff);
                        rsp_item_in.status      = iocr_pkg::STATUS_OK;
                     end
                  end
               end
               iocr_pkg::REQ_COMPLETE: begin
                  if (slot_ok && mem_rd_meta.state == iocr_pkg::SLOT_DISPATCHED) begin
                     mem_wr_addr          = PW'(req_ff.slot_in);
                     mem_meta_wr_en       = 1'b1;
                     mem_wr_meta.end_mark = mem_rd_meta.end_mark;
                     mem_wr_meta.state    = iocr_pkg::SLOT_DONE;
                     rsp_item_in.status   = iocr_pkg::STATUS_OK;
                  end
               end
               iocr_pkg::REQ_RETIRE: begin
                  if (mem_rd_meta.state == iocr_pkg::SLOT_DONE) begin
                     if (mem_rd_meta.end_mark) begin
                        rsp_item_in.status = iocr_pkg::STATUS_END;
                     end else begin
                        mem_wr_addr             = retire_ff;
                        mem_meta_wr_en          = 1'b1;
                        mem_wr_meta.state       = iocr_pkg::SLOT_FREE;
                        rsp_item_in.payload_out = PAY_W'(mem_rd_data);
                        retire_in               = ring_next(retire_ff);
                        retired                 = 1'b1;
                        rsp_item_in.status      = iocr_pkg::STATUS_OK;
                     end
                  end
               end
               iocr_pkg::REQ_TRUNCATE: begin
                  fill_in            = dispatch_ff;
                  mem_wr_addr        = ring_next(dispatch_ff);
                  mem_meta_wr_en     = 1'b1;
                  mem_wr_meta.state  = iocr_pkg::SLOT_FREE;
                  rsp_item_in.status = iocr_pkg::STATUS_OK;
               end
               iocr_pkg::REQ_FINISH: begin
                  mem_wr_addr          = dispatch_ff;
                  mem_meta_wr_en       = 1'b1;
                  mem_wr_meta.end_mark = 1'b1;
                  mem_wr_meta.state    = iocr_pkg::SLOT_DONE;
                  rsp_item_in.status   = iocr_pkg::STATUS_OK;
               end
               default: begin
                  rsp_item_in.status = iocr_pkg::STATUS_NOT_READY;
               end
            endcase
         end
         default: begin
            state_in = CTRL_CLEAR;
         end
      endcase

      // occupancy after the request
      occ_wide = (fill_in >= retire_in)
         ? ({1'b0, fill_in} - {1'b0, retire_in})
         : ({1'b0, fill_in} + (PW + 1)'(CAPACITY) - {1'b0, retire_in});
      occ = occ_wide[PW-1:0];
      rsp_item_in.occupancy    = SLOT_W'(occ);
      rsp_item_in.below_cordon = retired & (CMP_W'(occ) < cordon_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= CTRL_CLEAR;
         clear_ptr_ff  <= '0;
         fill_ff       <= '0;
         dispatch_ff   <= '0;
         retire_ff     <= '0;
         cordon_ff     <= CMP_W'(CORDON_RESET_EFF);
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_ptr_ff  <= clear_ptr_in;
         fill_ff       <= fill_in;
         dispatch_ff   <= dispatch_in;
         retire_ff     <= retire_in;
         cordon_ff     <= cordon_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_item;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_strobe_ff)
      else $error("accepted request produced no response");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == CTRL_EXEC))
      else $error("response without an execute cycle");

   a_not_ready_no_change: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_item_ff.status == iocr_pkg::STATUS_NOT_READY)
         |-> ($stable(fill_ff) && $stable(dispatch_ff) && $stable(retire_ff)))
      else $error("not-ready request moved a pointer");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CTRL_IDLE) |-> !(mem_meta_wr_en || mem_data_wr_en))
      else $error("memory write while idle");

   a_below_on_retire: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_item_ff.below_cordon)
         |-> (rsp_item_ff.status == iocr_pkg::STATUS_OK)
             && ($past(req_ff.req_type) == iocr_pkg::REQ_RETIRE))
      else $error("low-water flag outside a successful retire");

endmodule

/* design/in_order_completion_ring.sv */
// In-order completion ring: a request is taken when start is high and busy is low, and its
// response shows on rsp_item for exactly one cycle, marked by rsp_strobe, registered after
// the execute state; the receiver cannot stall and must capture it at the end of that cycle.
// Each request reads the slot memories, then modifies and writes back in the execute state
// with busy high; a new request can be taken once the block is idle again, while the previous
// response is on the ports. After reset the block runs a clearing pass over the slot state
// memory, busy high until it is done. The low-water register may be written at any time the
// block is idle; values under three tenths of CAPACITY are set to that figure rounded down.
module in_order_completion_ring #(
   parameter int CAPACITY   = iocr_pkg::CAPACITY_DEFAULT,
   parameter int DATA_WIDTH = iocr_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  iocr_pkg::req_item_type        req_item,
   output logic                          rsp_strobe,
   output iocr_pkg::rsp_item_type        rsp_item,
   input  logic                          csr_wr_en,
   input  logic [iocr_pkg::CORDON_W-1:0] csr_wr_data
);

   localparam int PW = $clog2(CAPACITY);

   logic                    mem_rd_en;
   logic [PW-1:0]           mem_rd_addr;
   iocr_pkg::slot_meta_type mem_rd_meta;
   logic [DATA_WIDTH-1:0]   mem_rd_data;
   logic [PW-1:0]           mem_wr_addr;
   logic                    mem_meta_wr_en;
   iocr_pkg::slot_meta_type mem_wr_meta;
   logic                    mem_data_wr_en;
   logic [DATA_WIDTH-1:0]   mem_wr_data;

   iocr_ctrl #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_item       (req_item),
      .busy           (busy),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_meta    (mem_rd_meta),
      .mem_rd_data    (mem_rd_data),
      .mem_wr_addr    (mem_wr_addr),
      .mem_meta_wr_en (mem_meta_wr_en),
      .mem_wr_meta    (mem_wr_meta),
      .mem_data_wr_en (mem_data_wr_en),
      .mem_wr_data    (mem_wr_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_item       (rsp_item)
   );

   iocr_slot_store #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_slot_store (
      .clock      (clock),
      .rd_en      (mem_rd_en),
      .rd_addr    (mem_rd_addr),
      .rd_meta    (mem_rd_meta),
      .rd_data    (mem_rd_data),
      .wr_addr    (mem_wr_addr),
      .meta_wr_en (mem_meta_wr_en),
      .wr_meta    (mem_wr_meta),
      .data_wr_en (mem_data_wr_en),
      .wr_data    (mem_wr_data)
   );

endmodule

/* bench/completion_ring_checker.sv */
`timescale 1ns / 100ps

module completion_ring_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  iocr_pkg::req_item_type        req_item,
   input  logic                          rsp_strobe,
   input  iocr_pkg::rsp_item_type        rsp_item,
   input  logic                          csr_wr_en,
   input  logic [iocr_pkg::CORDON_W-1:0] csr_wr_data,
   output int                            mismatches,
   output logic                          drained
);
   import iocr_pkg::*;

   localparam int RING = CAPACITY_DEFAULT;
   localparam int LOW_WATER_NUM = 3;
   localparam int LOW_WATER_DEN = 10;
   localparam int SHOWN_MAX = 100;

   logic [PAYLOAD_W-1:0] word_q [RING];
   logic                 end_q [RING];
   logic [STATE_W-1:0]   state_q [RING];
   logic [SLOT_W-1:0]    fill_ptr;
   logic [SLOT_W-1:0]    disp_ptr;
   logic [SLOT_W-1:0]    retire_ptr;
   logic [CORDON_W-1:0]  cordon;
   rsp_item_type         pending_responses [$];
   int                   accepted_cnt = 0;
   int                   checked_cnt = 0;

   assign drained = (accepted_cnt == checked_cnt);

   task automatic report_mismatch(input string what, input logic [PAYLOAD_W-1:0] got,
                                  input logic [PAYLOAD_W-1:0] want);
      if (mismatches < SHOWN_MAX) begin
         $display("[%0t] mismatch on response %0d, %s: got %h expected %h",
                  $time, checked_cnt, what, got, want);
      end
      mismatches = mismatches + 1;
   endtask

   function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] p);
      return (int'(p) == RING - 1) ? '0 : p + 1'b1;
   endfunction

   function automatic rsp_item_type ring_apply(input req_item_type r);
      rsp_item_type      o;
      logic [SLOT_W-1:0] occ;
      int                water;
      o = '0;
      o.status = STATUS_NOT_READY;
      case (r.req_type)
         REQ_PUSH: begin
            if (state_q[ring_next(fill_ptr)] == SLOT_FREE) begin
               word_q[fill_ptr] = r.payload;
               end_q[fill_ptr] = r.is_end;
               state_q[fill_ptr] = SLOT_FILLED;
               if (!r.is_end) fill_ptr = ring_next(fill_ptr);
               o.status = STATUS_OK;
            end
         end
         REQ_DISPATCH: begin
            if (state_q[disp_ptr] == SLOT_FILLED) begin
               if (end_q[disp_ptr]) begin
                  o.status = STATUS_END;
               end else begin
                  state_q[disp_ptr] = SLOT_DISPATCHED;
                  o.slot_out = disp_ptr;
                  o.payload_out = word_q[disp_ptr];
                  disp_ptr = ring_next(disp_ptr);
                  o.status = STATUS_OK;
               end
            end
         end
         REQ_COMPLETE: begin
            if (state_q[r.slot_in] == SLOT_DISPATCHED) begin
               state_q[r.slot_in] = SLOT_DONE;
               o.status = STATUS_OK;
            end
         end
         REQ_RETIRE: begin
            if (state_q[retire_ptr] == SLOT_DONE) begin
               if (end_q[retire_ptr]) begin
                  o.status = STATUS_END;
               end else begin
                  o.payload_out = word_q[retire_ptr];
                  state_q[retire_ptr] = SLOT_FREE;
                  retire_ptr = ring_next(retire_ptr);
                  water = (int'(cordon) * LOW_WATER_DEN < LOW_WATER_NUM * RING) ?
                          LOW_WATER_NUM * RING / LOW_WATER_DEN : int'(cordon);
                  occ = fill_ptr - retire_ptr;
                  o.below_cordon = (int'(occ) < water);
                  o.status = STATUS_OK;
               end
            end
         end
         REQ_TRUNCATE: begin
            fill_ptr = disp_ptr;
            state_q[ring_next(fill_ptr)] = SLOT_FREE;
            o.status = STATUS_OK;
         end
         REQ_FINISH: begin
            end_q[disp_ptr] = 1'b1;
            state_q[disp_ptr] = SLOT_DONE;
            o.status = STATUS_OK;
         end
         default: begin
         end
      endcase
      o.occupancy = fill_ptr - retire_ptr;
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         foreach (word_q[i]) begin
            word_q[i] = '0;
            end_q[i] = 1'b0;
            state_q[i] = SLOT_FREE;
         end
         fill_ptr = '0;
         disp_ptr = '0;
         retire_ptr = '0;
         cordon = CORDON_W'(CORDON_RESET);
         pending_responses.delete();
         mismatches = 0;
         accepted_cnt <= 0;
         checked_cnt <= 0;
      end else begin
         if (rsp_strobe) begin
            if (pending_responses.size() == 0) begin
               report_mismatch("response with no request outstanding",
                               PAYLOAD_W'(1), PAYLOAD_W'(0));
            end else begin
               want = pending_responses[0];
               pending_responses.delete(0);
               if (rsp_item.status !== want.status)
                  report_mismatch("status", PAYLOAD_W'(rsp_item.status),
                                  PAYLOAD_W'(want.status));
               if (rsp_item.slot_out !== want.slot_out)
                  report_mismatch("slot_out", PAYLOAD_W'(rsp_item.slot_out),
                                  PAYLOAD_W'(want.slot_out));
               if (rsp_item.payload_out !== want.payload_out)
                  report_mismatch("payload_out", rsp_item.payload_out, want.payload_out);
               if (rsp_item.occupancy !== want.occupancy)
                  report_mismatch("occupancy", PAYLOAD_W'(rsp_item.occupancy),
                                  PAYLOAD_W'(want.occupancy));
               if (rsp_item.below_cordon !== want.below_cordon)
                  report_mismatch("below_cordon", PAYLOAD_W'(rsp_item.below_cordon),
                                  PAYLOAD_W'(want.below_cordon));
               checked_cnt <= checked_cnt + 1;
            end
         end
         if (csr_wr_en) cordon = csr_wr_data;
         if (start && !busy) begin
            want = ring_apply(req_item);
            pending_responses = {pending_responses, want};
            accepted_cnt <= accepted_cnt + 1;
         end
      end
   end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
   import iocr_pkg::*;

   localparam logic [REQ_TYPE_W-1:0] REQ_RESERVED_A = 3'd6;
   localparam logic [REQ_TYPE_W-1:0] REQ_RESERVED_B = 3'd7;
   localparam int RING = CAPACITY_DEFAULT;
   localparam int RANDOM_REQUESTS = 800;
   localparam int PHASES = 4;
   localparam int STALL_TRIGGER = 10;
   localparam int CYCLE_LIMIT = 200000;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_item_type          req_item = '0;
   logic                  rsp_strobe;
   rsp_item_type          rsp_item;
   logic                  csr_wr_en = 1'b0;
   logic [CORDON_W-1:0]   csr_wr_data = '0;
   int                    mismatches;
   logic                  drained;
   int                    cycle_count = 0;

   logic [REQ_TYPE_W-1:0] sent_types [$];
   logic [SLOT_W-1:0]     live_slots [$];
   int                    stall_run = 0;
   bit                    steady = 1'b0;

   in_order_completion_ring dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   completion_ring_checker ring_check (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .mismatches(mismatches),
      .drained(drained)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL in_order_completion_ring");
         $finish;
      end
   end

   // track dispatched slots and runs of refused requests to steer the stimulus
   always @(negedge clock) begin
      logic [REQ_TYPE_W-1:0] kind;
      if (rsp_strobe && sent_types.size() != 0) begin
         kind = sent_types[0];
         sent_types.delete(0);
         if (rsp_item.status == STATUS_OK) begin
            stall_run = 0;
            if (kind == REQ_DISPATCH) begin
               live_slots = {live_slots, rsp_item.slot_out};
               if (live_slots.size() > RING) live_slots.delete(0);
            end
         end else begin
            stall_run++;
         end
      end
   end

   task automatic send(input req_item_type r);
      req_item <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      sent_types = {sent_types, r.req_type};
   endtask

   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (!drained);
   endtask

   task automatic write_cordon(input logic [CORDON_W-1:0] value);
      csr_wr_data <= value;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic req_item_type make_req(input logic [REQ_TYPE_W-1:0] kind,
                                             input logic [PAYLOAD_W-1:0] word,
                                             input logic mark,
                                             input logic [SLOT_W-1:0] slot);
      req_item_type r;
      r.req_type = kind;
      r.payload = word;
      r.is_end = mark;
      r.slot_in = slot;
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic req_item_type next_request();
      req_item_type r;
      int roll;
      int pick;
      bit from_list;
      from_list = 1'b0;
      r.payload = $urandom;
      if ($urandom_range(0, 9) == 0) r.payload = $urandom_range(0, 1) ? '1 : '0;
      r.is_end = 1'($urandom_range(0, 1));
      r.slot_in = SLOT_W'($urandom_range(0, RING - 1));
      roll = $urandom_range(0, 99);
      if (stall_run >= STALL_TRIGGER) begin
         if (roll < 25) r.req_type = REQ_TRUNCATE;
         else if (roll < 60) r.req_type = REQ_PUSH;
         else if (roll < 75) r.req_type = REQ_DISPATCH;
         else if (roll < 90) r.req_type = REQ_RETIRE;
         else r.req_type = REQ_COMPLETE;
         if (r.req_type == REQ_PUSH) r.is_end = 1'b0;
      end else begin
         if (roll < 28) begin
            r.req_type = REQ_PUSH;
            r.is_end = 1'b0;
         end else if (roll < 31) begin
            r.req_type = REQ_PUSH;
            r.is_end = 1'b1;
         end else if (roll < 53) begin
            r.req_type = REQ_DISPATCH;
         end else if (roll < 73) begin
            r.req_type = REQ_COMPLETE;
            from_list = 1'b1;
         end else if (roll < 91) begin
            r.req_type = REQ_RETIRE;
         end else if (roll < 93) begin
            r.req_type = REQ_FINISH;
         end else if (roll < 95) begin
            r.req_type = REQ_TRUNCATE;
         end else if (roll < 98) begin
            r.req_type = REQ_COMPLETE;
         end else begin
            r.req_type = $urandom_range(0, 1) ? REQ_RESERVED_A : REQ_RESERVED_B;
         end
      end
      if (from_list && live_slots.size() != 0) begin
         pick = $urandom_range(0, live_slots.size() - 1);
         r.slot_in = live_slots[pick];
         live_slots.delete(pick);
      end
      return r;
   endfunction

   initial begin
      logic [CORDON_W-1:0] cordon_plan [PHASES];
      req_item_type        r;
      int                  sent;
      cordon_plan = '{5'd16, 5'd4, 5'd10, 5'd7};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (!busy);
      do @(posedge clock); while (busy);

      // directed part, cordon at its reset value
      send(make_req(REQ_RETIRE, '0, 1'b0, 4'd0));
      send(make_req(REQ_DISPATCH, '1, 1'b1, 4'd15));
      send(make_req(REQ_COMPLETE, '1, 1'b1, 4'd15));
      send(make_req(REQ_RESERVED_A, 32'h0F0F_0F0F, 1'b0, 4'd3));
      send(make_req(REQ_RESERVED_B, 32'hF0F0_F0F0, 1'b1, 4'd12));
      send(make_req(REQ_PUSH, '0, 1'b0, 4'd15));
      send(make_req(REQ_PUSH, '1, 1'b0, 4'd0));
      send(make_req(REQ_PUSH, 32'hA5A5_A5A5, 1'b0, 4'd9));
      send(make_req(REQ_DISPATCH, '0, 1'b0, 4'd0));
      send(make_req(REQ_DISPATCH, '0, 1'b0, 4'd0));
      send(make_req(REQ_COMPLETE, '0, 1'b0, 4'd1));
      send(make_req(REQ_RETIRE, '0, 1'b0, 4'd0));
      send(make_req(REQ_COMPLETE, '0, 1'b0, 4'd0));
      send(make_req(REQ_RETIRE, '0, 1'b0, 4'd0));
      send(make_req(REQ_RETIRE, '0, 1'b0, 4'd0));
      send(make_req(REQ_PUSH, 32'h1234_5678, 1'b1, 4'd0));
      send(make_req(REQ_DISPATCH, '0, 1'b0, 4'd0));
      send(make_req(REQ_DISPATCH, '0, 1'b0, 4'd0));
      send(make_req(REQ_PUSH, 32'h5A5A_5A5A, 1'b0, 4'd15));
      send(make_req(REQ_FINISH, '0, 1'b0, 4'd0));
      send(make_req(REQ_COMPLETE, '0, 1'b0, 4'd2));
      send(make_req(REQ_RETIRE, '0, 1'b0, 4'd0));
      send(make_req(REQ_RETIRE, '0, 1'b0, 4'd0));
      send(make_req(REQ_TRUNCATE, '0, 1'b0, 4'd0));
      send(make_req(REQ_PUSH, 32'hDEAD_0001, 1'b0, 4'd0));

      for (int p = 0; p < PHASES; p++) begin
         drain();
         write_cordon(cordon_plan[p]);
         sent = 0;
         while (sent < RANDOM_REQUESTS / PHASES) begin
            if (sent % 40 == 0) steady = ($urandom_range(0, 3) == 0);
            r = next_request();
            send(r);
            if (r.req_type != REQ_RESERVED_A && r.req_type != REQ_RESERVED_B) sent++;
            if ($urandom_range(0, 199) == 0) drain();
            else hold_off(pick_gap());
         end
      end

      drain();
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS in_order_completion_ring");
      end else begin
         $display("FAIL in_order_completion_ring");
      end
      $finish;
   end

endmodule
